// ----- design/bhfs_pkg.sv -----
// Shared types and constants for the buffer handle free stack.
`default_nettype none
package bhfs_pkg;

    localparam int HandleW = 8;
    localparam int CountW  = 9;

    localparam logic ReqAlloc = 1'b0;
    localparam logic ReqFree  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_SKIP  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the request word and start the stack read
        logic commit;  // apply the request and load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register is empty or is being taken
    } t_stat;

endpackage
`default_nettype wire

// ----- design/bhfs_req_if.sv -----
// Request channel: valid, ready and the request word.
`default_nettype none
interface bhfs_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] handle_in;
    logic       batch_end;

    modport source (output valid, output req_type, output handle_in, output batch_end,
                    input ready);
    modport sink (input valid, input req_type, input handle_in, input batch_end,
                  output ready);
endinterface
`default_nettype wire

// ----- design/bhfs_rsp_if.sv -----
// Response channel: valid, ready and the result word.
`default_nettype none
interface bhfs_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] handle_out;
    logic [8:0] busy_now;
    logic [8:0] busy_peak;

    modport source (output valid, output status, output handle_out, output busy_now,
                    output busy_peak, input ready);
    modport sink (input valid, input status, input handle_out, input busy_now,
                  input busy_peak, output ready);
endinterface
`default_nettype wire

// ----- design/bhfs_ctrl.sv -----
// Controller state machine for the buffer handle free stack.
`default_nettype none
module bhfs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  bhfs_pkg::t_stat     i_stat,
    output bhfs_pkg::t_cmd      o_cmd
);
    import bhfs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // Wait here while a previous result still sits unclaimed.
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/bhfs_dp.sv -----
// Datapath: stack memory, busy counters, batch flag and output register.
`default_nettype none
module bhfs_dp #(
    parameter int POOL_SIZE = 256
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  bhfs_pkg::t_cmd       i_cmd,
    output bhfs_pkg::t_stat      o_stat,
    input  wire logic            i_req_type,
    input  wire logic [7:0]      i_handle_in,
    input  wire logic            i_batch_end,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic [1:0]           o_status,
    output logic [7:0]           o_handle_out,
    output logic [8:0]           o_busy_now,
    output logic [8:0]           o_busy_peak
);
    import bhfs_pkg::*;

    localparam int AW = $clog2(POOL_SIZE);
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam logic [CW-1:0] PoolCount = CW'(POOL_SIZE);

    logic [HandleW-1:0] mem [POOL_SIZE];

    logic [CW-1:0]      r_busy;
    logic [CW-1:0]      r_peak;
    logic               r_skip;
    logic               r_req_type;
    logic [HandleW-1:0] r_handle;
    logic               r_last;
    logic               r_use_mem;
    logic [HandleW-1:0] r_init_handle;
    logic [HandleW-1:0] r_rd_data;

    logic               r_out_valid;
    t_status            r_status;
    logic [HandleW-1:0] r_hout;
    logic [CountW-1:0]  r_busy_now;
    logic [CountW-1:0]  r_busy_peak;

    logic [CW-1:0]      n_busy;
    logic [CW-1:0]      n_peak;
    logic               n_skip;
    t_status            w_status;
    logic [HandleW-1:0] w_hout;
    logic               w_push;
    logic               w_pool_empty;
    logic [CW-1:0]      w_top_idx;
    logic [CW-1:0]      w_push_idx;

    assign w_pool_empty = (r_busy == PoolCount);
    assign w_top_idx    = CW'(PoolCount - r_busy - CW'(1));
    assign w_push_idx   = CW'(PoolCount - r_busy);

    // Capture the request. An entry below the lowest free count ever reached
    // has never been popped, so it still holds its reset handle; that is the
    // case exactly when the busy count has never been above its current value.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type    <= i_req_type;
            r_handle      <= i_handle_in;
            r_last        <= i_batch_end;
            r_use_mem     <= (r_busy < r_peak);
            r_init_handle <= HandleW'(w_top_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_pool_empty) begin
            r_rd_data <= mem[w_top_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_push) begin
            mem[w_push_idx[AW-1:0]] <= r_handle;
        end
    end

    always_comb begin
        n_busy   = r_busy;
        n_peak   = r_peak;
        n_skip   = r_skip;
        w_status = ST_OK;
        w_hout   = '0;
        w_push   = 1'b0;
        if (r_req_type == ReqAlloc) begin
            if (w_pool_empty) begin
                w_status = ST_EMPTY;
            end else begin
                w_hout = r_use_mem ? r_rd_data : r_init_handle;
                n_busy = CW'(r_busy + CW'(1));
                if (n_busy > r_peak) begin
                    n_peak = n_busy;
                end
            end
        end else if (r_skip) begin
            w_status = ST_SKIP;
            if (r_last) begin
                n_skip = 1'b0;
            end
        end else if (r_busy == '0) begin
            w_status = ST_FULL;
            if (!r_last) begin
                n_skip = 1'b1;
            end
        end else begin
            w_push = 1'b1;
            n_busy = CW'(r_busy - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            r_peak <= '0;
            r_skip <= 1'b0;
        end else if (i_cmd.commit) begin
            r_busy <= n_busy;
            r_peak <= n_peak;
            r_skip <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status    <= w_status;
            r_hout      <= w_hout;
            r_busy_now  <= CountW'(n_busy);
            r_busy_peak <= CountW'(n_peak);
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = 2'(r_status);
    assign o_handle_out    = r_hout;
    assign o_busy_now      = r_busy_now;
    assign o_busy_peak     = r_busy_peak;

    a_busy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy <= PoolCount)
        else $error("busy count above pool size");

    a_peak_covers_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_busy)
        else $error("high-water mark below busy count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result committed over an unclaimed result");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed result not presented");

endmodule
`default_nettype wire

// ----- design/buffer_handle_free_stack_top.sv -----
// Top level of the buffer handle free stack allocator.
//
//  Channel  Dir  Handshake      Word contents
//  i_req    in   valid/ready    req_type, handle_in, batch_end
//  o_rsp    out  valid/ready    status, handle_out, busy_now, busy_peak
//
// Each request passes through S_IDLE and S_EXEC. In S_IDLE the request word
// is accepted and the stack memory is read at the top of stack; in S_EXEC,
// once the output register is free, the request is applied and its result
// loaded into the output register; no new request is taken meanwhile. The
// stack read is registered, hence the separate states. Reset is synchronous;
// there is no clearing pass over the stack. An entry that was never popped
// still yields its reset handle, found by comparing the busy count with its
// high-water mark. A new request is accepted while the previous result waits
// in the output register; a request finishes only once that register is free.
`default_nettype none
module buffer_handle_free_stack_top #(
    parameter int POOL_SIZE = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bhfs_req_if.sink    i_req,
    bhfs_rsp_if.source  o_rsp
);
    import bhfs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    bhfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bhfs_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_req_type   (i_req.req_type),
        .i_handle_in  (i_req.handle_in),
        .i_batch_end  (i_req.batch_end),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_handle_out (o_rsp.handle_out),
        .o_busy_now   (o_rsp.busy_now),
        .o_busy_peak  (o_rsp.busy_peak)
    );

endmodule
`default_nettype wire

// ----- tb/tb_buffer_handle_free_stack_top.sv -----
// Testbench for the buffer handle free stack: directed table, random phases, self-checking.
`timescale 1ns / 1ps
`default_nettype none
module tb_buffer_handle_free_stack_top;
    import bhfs_pkg::*;

    localparam int POOL_SIZE   = 256;
    localparam int RandomWords = 1000;
    localparam int HoldAt      = 300;     // words sent before the long response stall
    localparam int HoldCycles  = 200;     // length of that stall
    localparam int CycleLimit  = 200000;  // far above the slowest correct run
    localparam int DirRowN     = 19;

    // One result word as the block reports it.
    typedef struct packed {
        t_status    status;
        logic [7:0] handle;
        logic [8:0] busy;
        logic [8:0] peak;
    } t_rsp_word;

    // One row of the directed table. Where typed is set, the row carries its
    // expected result; otherwise the predictor supplies it.
    typedef struct packed {
        logic       req;
        logic [7:0] handle;
        logic       bend;
        logic       typed;
        t_status    status;
        logic [7:0] hout;
        logic [8:0] busy;
        logic [8:0] peak;
    } t_dir_row;

    // The first rows start from the reset state, where every handle is free
    // and the highest handle sits on top of the stack.
    t_dir_row dir_rows [0:DirRowN-1] = '{
        // free into a full pool, single free
        '{ReqFree,  8'h00, 1'b1, 1'b1, ST_FULL, 8'h00, 9'd0, 9'd0},
        // free into a full pool inside a batch starts skipping
        '{ReqFree,  8'hFF, 1'b0, 1'b1, ST_FULL, 8'h00, 9'd0, 9'd0},
        '{ReqFree,  8'h12, 1'b0, 1'b1, ST_SKIP, 8'h00, 9'd0, 9'd0},
        // allocate while skipping is served and pops the highest handle
        '{ReqAlloc, 8'hFF, 1'b1, 1'b1, ST_OK,   8'hFF, 9'd1, 9'd1},
        // end of batch while skipping closes the batch
        '{ReqFree,  8'h34, 1'b1, 1'b1, ST_SKIP, 8'h00, 9'd1, 9'd1},
        // unchecked free of a handle that was never allocated
        '{ReqFree,  8'hAA, 1'b1, 1'b1, ST_OK,   8'h00, 9'd0, 9'd1},
        '{ReqAlloc, 8'h00, 1'b0, 1'b1, ST_OK,   8'hAA, 9'd1, 9'd1},
        // this entry was never popped, so it still yields its reset handle
        '{ReqAlloc, 8'h55, 1'b1, 1'b1, ST_OK,   8'hFE, 9'd2, 9'd2},
        // a batch that runs the pool full before its end
        '{ReqFree,  8'h00, 1'b0, 1'b0, ST_OK,   8'h00, 9'd0, 9'd0},
        '{ReqFree,  8'hFF, 1'b0, 1'b0, ST_OK,   8'h00, 9'd0, 9'd0},
        '{ReqFree,  8'h80, 1'b0, 1'b1, ST_FULL, 8'h00, 9'd0, 9'd2},
        '{ReqFree,  8'h7F, 1'b1, 1'b1, ST_SKIP, 8'h00, 9'd0, 9'd2},
        '{ReqAlloc, 8'h01, 1'b0, 1'b0, ST_OK,   8'h00, 9'd0, 9'd0},
        '{ReqAlloc, 8'hFE, 1'b1, 1'b0, ST_OK,   8'h00, 9'd0, 9'd0},
        // the same handle freed twice is pushed twice
        '{ReqFree,  8'h00, 1'b1, 1'b0, ST_OK,   8'h00, 9'd0, 9'd0},
        '{ReqFree,  8'h00, 1'b1, 1'b0, ST_OK,   8'h00, 9'd0, 9'd0},
        '{ReqAlloc, 8'h00, 1'b0, 1'b0, ST_OK,   8'h00, 9'd0, 9'd0},
        '{ReqAlloc, 8'h00, 1'b0, 1'b0, ST_OK,   8'h00, 9'd0, 9'd0},
        '{ReqAlloc, 8'h00, 1'b0, 1'b0, ST_OK,   8'h00, 9'd0, 9'd0}
    };

    logic i_clk;
    logic i_rst_n;

    bhfs_req_if req_ch ();
    bhfs_rsp_if rsp_ch ();

    buffer_handle_free_stack_top #(
        .POOL_SIZE (POOL_SIZE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the allocator state, advanced once per accepted request.
    logic [7:0] pool_stack [0:POOL_SIZE-1];
    logic [8:0] busy_shadow;
    logic [8:0] peak_shadow;
    logic       skip_shadow;

    t_rsp_word   pending_q [$];   // results owed by the block, oldest first
    int unsigned words_sent;
    int unsigned words_seen;
    int unsigned mismatches;
    int unsigned status_seen [4];
    int unsigned cycles;
    logic        rsp_hold;        // forces the response side to stall
    logic        steady;          // when set, neither side idles

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The run is cut short if it goes on far longer than any correct run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("timeout after %0d cycles, %0d results still owed", cycles,
                     pending_q.size());
            $display("tb_buffer_handle_free_stack_top failed");
            $finish;
        end
    end

    // Applies one request to the shadow state and returns the result it owes.
    function automatic t_rsp_word serve_request(input logic rt, input logic [7:0] h,
                                                input logic be);
        t_rsp_word r;
        int        free_n;
        r.status = ST_OK;
        r.handle = '0;
        free_n   = POOL_SIZE - int'(busy_shadow);
        if (rt == ReqAlloc) begin
            if (free_n == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.handle    = pool_stack[free_n - 1];
                busy_shadow = busy_shadow + 9'd1;
                if (busy_shadow > peak_shadow) peak_shadow = busy_shadow;
            end
        end else if (skip_shadow) begin
            r.status = ST_SKIP;
            if (be) skip_shadow = 1'b0;
        end else if (busy_shadow == '0) begin
            // A failure before the end of a batch skips what is left of it.
            r.status = ST_FULL;
            if (!be) skip_shadow = 1'b1;
        end else begin
            pool_stack[free_n] = h;
            busy_shadow        = busy_shadow - 9'd1;
        end
        r.busy = busy_shadow;
        r.peak = peak_shadow;
        return r;
    endfunction

    // Offers one request word and returns once it is taken. Valid stays high
    // after the handshake, so back-to-back words never drop it within a step.
    task automatic offer_word(input logic rt, input logic [7:0] h, input logic be,
                              output t_rsp_word owed);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rt;
        req_ch.handle_in <= h;
        req_ch.batch_end <= be;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        owed = serve_request(rt, h, be);
        words_sent++;
    endtask

    task automatic issue(input logic rt, input logic [7:0] h, input logic be);
        t_rsp_word owed;
        offer_word(rt, h, be, owed);
        pending_q.push_back(owed);
    endtask

    // The sender drops valid and holds back until every owed result has come
    // back, so the last word is not taken a second time.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Random allocates and frees; most frees are single, some open a batch.
    task automatic run_mix(input int n);
        repeat (n) begin
            issue(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 3) != 0));
        end
    endtask

    // Allocates until the pool is empty, then a few more to see it refuse.
    task automatic run_drain();
        int n;
        n = POOL_SIZE - int'(busy_shadow) + $urandom_range(2, 5);
        repeat (n) issue(ReqAlloc, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Frees until every handle is back, then a few more with random batch
    // ends, so that full pools and skipped batches both show up.
    task automatic run_refill();
        int n;
        n = int'(busy_shadow) + $urandom_range(2, 6);
        repeat (n) issue(ReqFree, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Well-formed free batches closed by an end flag, now and then with an
    // allocate slipped in between.
    task automatic run_batches(input int nb);
        int len;
        repeat (nb) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 3) == 0)
                    issue(ReqAlloc, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                issue(ReqFree, 8'($urandom_range(0, 255)), 1'(k == len - 1));
            end
        end
    endtask

    // Response side: a random pause per word, plus the long stall on request.
    initial begin : rsp_sink
        int unsigned pause;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            pause = steady ? 0 : $urandom_range(0, 9);
            if (pause != 0 || rsp_hold) begin
                rsp_ch.ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
                while (rsp_hold) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // Once the run is under way, the response side stops taking words for a
    // long stretch while requests keep coming, so the block backs up.
    initial begin : long_stall
        int unsigned held;
        rsp_hold <= 1'b0;
        @(posedge i_clk);
        while (words_sent < HoldAt) @(posedge i_clk);
        rsp_hold <= 1'b1;
        for (held = 0; held < HoldCycles; held++) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    // Every accepted result word is matched against the oldest owed result.
    always @(posedge i_clk) begin : rsp_check
        t_rsp_word want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            words_seen++;
            status_seen[rsp_ch.status]++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d handle %0d busy %0d peak %0d",
                             rsp_ch.status, rsp_ch.handle_out, rsp_ch.busy_now,
                             rsp_ch.busy_peak);
            end else begin
                want = pending_q.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.handle_out !== want.handle ||
                    rsp_ch.busy_now !== want.busy || rsp_ch.busy_peak !== want.peak) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d mismatch: expected status %0d handle %0d ",
                                  "busy %0d peak %0d, got status %0d handle %0d busy %0d ",
                                  "peak %0d"}, words_seen, want.status, want.handle,
                                 want.busy, want.peak, rsp_ch.status, rsp_ch.handle_out,
                                 rsp_ch.busy_now, rsp_ch.busy_peak);
                end
            end
        end
    end

    initial begin : stimulus
        t_rsp_word owed;
        int        target;

        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= ReqAlloc;
        req_ch.handle_in <= '0;
        req_ch.batch_end <= 1'b0;
        i_rst_n          <= 1'b0;
        steady      = 1'b0;
        words_sent  = 0;
        words_seen  = 0;
        mismatches  = 0;
        status_seen = '{default: 0};
        for (int i = 0; i < POOL_SIZE; i++) pool_stack[i] = 8'(i);
        busy_shadow = '0;
        peak_shadow = '0;
        skip_shadow = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Typed rows replace the prediction with the value
        // written in the table; the shadow state still advances on them.
        for (int r = 0; r < DirRowN; r++) begin
            offer_word(dir_rows[r].req, dir_rows[r].handle, dir_rows[r].bend, owed);
            if (dir_rows[r].typed)
                pending_q.push_back('{dir_rows[r].status, dir_rows[r].hout,
                                      dir_rows[r].busy, dir_rows[r].peak});
            else
                pending_q.push_back(owed);
        end
        settle();

        // Random part: a mix, then the pool is emptied past its end (the long
        // stall lands here) and filled back past full, then batches with
        // no idling on either side, then random phases to the word budget.
        target = words_sent + RandomWords;
        run_mix(150);
        settle();
        run_drain();
        run_refill();
        settle();
        steady = 1'b1;
        run_batches(20);
        steady = 1'b0;
        while (words_sent < target) begin
            case ($urandom_range(0, 4))
                0: run_mix(60);
                1: run_batches(10);
                2: run_drain();
                3: run_refill();
                default: begin
                    // Noise: every field random, batch ends included.
                    repeat (30) issue(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)));
                end
            endcase
            if ($urandom_range(0, 2) == 0) settle();
        end

        settle();
        repeat (10) @(posedge i_clk);

        $display("%0d request words, %0d results: ok %0d, empty %0d, full %0d, skipped %0d",
                 words_sent, words_seen, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_FULL], status_seen[ST_SKIP]);
        $display("busy peak reached %0d of %0d handles, %0d mismatches", peak_shadow,
                 POOL_SIZE, mismatches);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("tb_buffer_handle_free_stack_top passed");
        end else begin
            $display("tb_buffer_handle_free_stack_top failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
design/bhfs_pkg.sv
design/bhfs_req_if.sv
design/bhfs_rsp_if.sv
design/bhfs_ctrl.sv
design/bhfs_dp.sv
design/buffer_handle_free_stack_top.sv
tb/tb_buffer_handle_free_stack_top.sv
